// ===== rtl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

    // Store geometry
    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Field widths
    localparam int TS_W       = 64;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);

    // Rank arithmetic widths
    localparam int PROD_W = CNT_W + FRAC_W;
    localparam int IDX_W  = PROD_W - FRAC_SHIFT + 1;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL,
        ST_IDX,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // item accepted this cycle
        logic mul;      // register count * fraction
        logic idx;      // form the clamped rank, initialise the search
        logic scan;     // at most one read of the store
        logic decide;   // settle one bit of the answer
        logic finish;   // result taken into the output stage, set cleared
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic last_bit;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/lps_ctrl.sv =====
`default_nettype none

module lps_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tlast,
    output logic                s_tready,
    input  wire logic           out_busy,
    input  wire lps_pkg::stat_t stat,
    output lps_pkg::cmd_t       cmd
);

    lps_pkg::state_t state_reg;
    lps_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lps_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lps_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = lps_pkg::ST_MUL;
                end
            end
            lps_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = lps_pkg::ST_IDX;
            end
            lps_pkg::ST_IDX: begin
                cmd.idx = 1'b1;
                if (stat.count_zero) begin
                    state_next = lps_pkg::ST_FINISH;
                end else begin
                    state_next = lps_pkg::ST_SCAN;
                end
            end
            lps_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = lps_pkg::ST_DECIDE;
                end
            end
            lps_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.last_bit) begin
                    state_next = lps_pkg::ST_FINISH;
                end else begin
                    state_next = lps_pkg::ST_SCAN;
                end
            end
            lps_pkg::ST_FINISH: begin
                // wait for the output stage to free up
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = lps_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = lps_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lps_dp.sv =====
`default_nettype none

module lps_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lps_pkg::cmd_t               cmd,
    output lps_pkg::stat_t                   stat,
    input  wire logic [lps_pkg::TS_W-1:0]    arrival_time,
    input  wire logic [lps_pkg::TS_W-1:0]    processed_time,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lps_pkg::FRAC_W-1:0]  cfg_wr_data,
    output logic [lps_pkg::TS_W-1:0]         latency,
    output logic                             none_valid,
    output logic                             overflowed
);

    // Latency store
    logic [lps_pkg::TS_W-1:0] mem [lps_pkg::MAX_ITEMS];
    logic [lps_pkg::TS_W-1:0] rd_data_reg;

    // Set state and configuration
    logic [lps_pkg::FRAC_W-1:0] frac_reg;
    logic [lps_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       ovf_reg, ovf_next;

    // Rank and radix search
    logic [lps_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [lps_pkg::CNT_W-1:0]  k_reg, k_next;
    logic [lps_pkg::CNT_W-1:0]  j_reg, j_next;
    logic [lps_pkg::CNT_W-1:0]  c_reg, c_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [lps_pkg::TS_W-1:0]   prefix_reg, prefix_next;
    logic [lps_pkg::TS_W-1:0]   mask_reg, mask_next;
    logic [lps_pkg::TS_W-1:0]   bit_sel_reg, bit_sel_next;

    logic                       item_ok;
    logic                       full;
    logic                       wr_en;
    logic [lps_pkg::TS_W-1:0]   lat;
    logic                       rd_issue;
    logic                       match;
    logic [lps_pkg::IDX_W-1:0]  idx_wide;

    // Pair check and latency
    assign lat      = processed_time - arrival_time;
    assign item_ok  = (processed_time != '0) && (processed_time >= arrival_time);
    assign full     = (count_reg == lps_pkg::CNT_W'(lps_pkg::MAX_ITEMS));
    assign wr_en    = cmd.load && item_ok && !full;
    assign rd_issue = cmd.scan && (j_reg < count_reg);

    // Value lies under the current prefix and has a zero at the bit in question
    assign match = (((rd_data_reg ^ prefix_reg) & mask_reg) == '0)
                && ((rd_data_reg & bit_sel_reg) == '0);

    // floor(count * fraction) + 1
    assign idx_wide = lps_pkg::IDX_W'(prod_reg[lps_pkg::PROD_W-1:lps_pkg::FRAC_SHIFT])
                    + lps_pkg::IDX_W'(1);

    // Store access
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[lps_pkg::ADDR_W-1:0]] <= lat;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[j_reg[lps_pkg::ADDR_W-1:0]];
        end
    end

    // Fraction register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= lps_pkg::FRAC_RESET;
        end else if (cfg_wr_en) begin
            frac_reg <= cfg_wr_data;
        end
    end

    // Next values
    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        prod_next    = prod_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        c_next       = c_reg;
        rd_vld_next  = rd_issue;
        prefix_next  = prefix_reg;
        mask_next    = mask_reg;
        bit_sel_next = bit_sel_reg;

        if (wr_en) begin
            count_next = count_reg + lps_pkg::CNT_W'(1);
        end
        if (cmd.load && item_ok && full) begin
            ovf_next = 1'b1;
        end
        if (cmd.finish) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end

        if (cmd.mul) begin
            prod_next = lps_pkg::PROD_W'(count_reg) * lps_pkg::PROD_W'(frac_reg);
        end

        // Clamp the rank and start from the top bit
        if (cmd.idx) begin
            if (idx_wide >= lps_pkg::IDX_W'(count_reg)) begin
                k_next = count_reg - lps_pkg::CNT_W'(1);
            end else begin
                k_next = idx_wide[lps_pkg::CNT_W-1:0];
            end
            j_next       = '0;
            c_next       = '0;
            rd_vld_next  = 1'b0;
            prefix_next  = '0;
            mask_next    = '0;
            bit_sel_next = {1'b1, {(lps_pkg::TS_W-1){1'b0}}};
        end

        // Counting pass
        if (rd_issue) begin
            j_next = j_reg + lps_pkg::CNT_W'(1);
        end
        if (rd_vld_reg && match) begin
            c_next = c_reg + lps_pkg::CNT_W'(1);
        end

        // Settle one bit: enough zeros below the rank keeps it zero
        if (cmd.decide) begin
            if (k_reg >= c_reg) begin
                k_next      = k_reg - c_reg;
                prefix_next = prefix_reg | bit_sel_reg;
            end
            mask_next    = mask_reg | bit_sel_reg;
            bit_sel_next = bit_sel_reg >> 1;
            j_next       = '0;
            c_next       = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Search registers
    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        c_reg       <= c_next;
        prefix_reg  <= prefix_next;
        mask_reg    <= mask_next;
        bit_sel_reg <= bit_sel_next;
    end

    // Status and result
    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_done  = (j_reg == count_reg) && !rd_vld_reg;
    assign stat.last_bit   = bit_sel_reg[0];

    assign latency    = stat.count_zero ? '0 : prefix_reg;
    assign none_valid = stat.count_zero;
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/latency_percentile_select.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: arrival_time, processed_time; tlast
// m_*       out        m_tvalid / m_tready  tdata: latency; tuser: none_valid, overflowed
// cfg_*     in         cfg_wr_en            fraction_q16, Q1.16
//
// Records load one per cycle into a 1024-entry store. The marked record starts
// selection: the rank is formed in the MUL and IDX states, then a bitwise radix
// search over the store runs 64 passes, each reading every stored value (one store
// read per cycle) and then settling one bit of the result; an empty set skips it.
// Synchronous active-low reset; the store itself is not cleared.
// Input is held off during selection and while a finished result still waits.

module latency_percentile_select (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [127:0]                s_tdata,   // arrival_time, processed_time
    input  wire logic                        s_tlast,   // last_record
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [63:0]                      m_tdata,   // latency
    output logic [1:0]                       m_tuser,   // none_valid, overflowed
    input  wire logic                        cfg_wr_en,
    input  wire logic [lps_pkg::FRAC_W-1:0]  cfg_wr_data
);

    lps_pkg::cmd_t              cmd;
    lps_pkg::stat_t             stat;
    logic                       out_busy;
    logic [lps_pkg::TS_W-1:0]   res_latency;
    logic                       res_none;
    logic                       res_ovf;

    logic                       m_tvalid_reg;
    logic [lps_pkg::TS_W-1:0]   m_tdata_reg;
    logic [1:0]                 m_tuser_reg;

    assign out_busy = m_tvalid_reg && !m_tready;

    lps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    lps_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .arrival_time   (s_tdata[63:0]),
        .processed_time (s_tdata[127:64]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .latency        (res_latency),
        .none_valid     (res_none),
        .overflowed     (res_ovf)
    );

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= res_latency;
            m_tuser_reg <= {res_ovf, res_none};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A finished set always shows up on the output next cycle
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("result not presented after finish");

    // An empty set reports zero latency
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("none_valid with nonzero latency");

    // Input stops after the marked record
    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted during selection");

    // Output stage never overwritten while stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.finish)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
